// File: hdl/rfp_pkg.sv
package rfp_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_CRC_POLY  = 2'd0,
		REG_SYNTH_ID  = 2'd1,
		REG_CTRL_ID   = 2'd2,
		REG_INTR_ID   = 2'd3
	} rfp_reg_t;

	localparam int unsigned CfgDataWidth = 16;
	localparam logic [15:0] CrcPolyReset = 16'h1021;

	// position within the frame
	typedef enum logic [3:0] {
		PH_ID   = 4'd0,
		PH_HDR  = 4'd1,
		PH_CTX  = 4'd2,
		PH_LEN0 = 4'd3,
		PH_LEN1 = 4'd4,
		PH_ADR0 = 4'd5,
		PH_ADR1 = 4'd6,
		PH_DATA = 4'd7,
		PH_CRC0 = 4'd8,
		PH_CRC1 = 4'd9,
		PH_DONE = 4'd10
	} rfp_phase_t;

	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_UNEXP    = 3'd1,
		ST_PARSING  = 3'd2,
		ST_COMPLETE = 3'd3,
		ST_CRCERR   = 3'd4
	} rfp_status_t;

	typedef enum logic {
		MODE_BYTE    = 1'b0,
		MODE_RESTART = 1'b1
	} rfp_mode_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] rx_byte;
	} rfp_byte_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  report_id;
		logic [7:0]  header_byte;
		logic [7:0]  context_byte;
		logic [15:0] frame_length;
		logic [15:0] target_address;
		logic [7:0]  data_byte;
		logic        data_valid;
		logic [15:0] data_index;
		logic        frame_end;
	} rfp_report_t;

	// msb-first crc-16 update by one byte, top bit of the polynomial implied
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b,
			input logic [15:0] poly);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ poly;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// File: hdl/rfp_if.sv
interface rfp_byte_if import rfp_pkg::*; ();
	logic      valid;
	logic      ready;
	rfp_byte_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface rfp_report_if import rfp_pkg::*; ();
	logic        valid;
	logic        ready;
	rfp_report_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/report_frame_parser_crc16_top.sv
// Report frame parser with CRC-16 check.
// byte_ch carries one word per received byte (mode, rx_byte); a word with
// mode set restarts the parser to idle. report_ch carries one word per
// accepted byte: the status after that byte, the frame fields seen so far,
// the payload byte with its index when the byte was payload, and frame_end
// on the byte that completed the CRC compare.
// Throughput is one byte per cycle while byte_ch.ready is high: the whole
// per-byte step, including the eight-bit CRC update, is one combinational
// pass into the result register. The result register drives report_ch.
// When the receiver stalls, one further word is taken into a skid register,
// after which byte_ch.ready drops until the result register drains.
// Configuration (polynomial, three frame IDs) is written through cfg_we,
// cfg_index, cfg_data, by the user only while idle; the block has no check.
// Reset clears the parser to idle, the frame registers and CRC to zero,
// the polynomial to 0x1021 and the IDs to zero; both output registers empty.
module report_frame_parser_crc16_top import rfp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [CfgDataWidth-1:0] cfg_data,
	rfp_byte_if.sink                byte_ch,
	rfp_report_if.source            report_ch
);

	logic [15:0] crc_poly_q;
	logic [7:0]  synth_id_q, ctrl_id_q, intr_id_q;

	rfp_phase_t  phase_q, phase_d;
	rfp_status_t status_q, status_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  crc_low_q, crc_low_d;
	logic [15:0] count_q, count_d;
	logic [7:0]  id_q, id_d, hdr_q, hdr_d, ctx_q, ctx_d;
	logic [15:0] len_q, len_d, adr_q, adr_d;

	rfp_report_t res;
	rfp_report_t out_s1, skid_s1;
	logic        out_vld_q, skid_vld_q;
	logic        accept;
	logic [7:0]  b;
	logic [15:0] count_inc;
	logic [15:0] crc_upd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_poly_q <= CrcPolyReset;
			synth_id_q <= '0;
			ctrl_id_q  <= '0;
			intr_id_q  <= '0;
		end else if (cfg_we) begin
			case (rfp_reg_t'(cfg_index))
				REG_CRC_POLY: crc_poly_q <= cfg_data;
				REG_SYNTH_ID: synth_id_q <= cfg_data[7:0];
				REG_CTRL_ID:  ctrl_id_q  <= cfg_data[7:0];
				REG_INTR_ID:  intr_id_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign accept    = byte_ch.valid && byte_ch.ready;
	assign b         = byte_ch.payload.rx_byte;
	assign count_inc = count_q + 16'd1;
	assign crc_upd   = crc16_byte((phase_q == PH_ID) ? 16'h0000 : crc_q, b, crc_poly_q);

	// per-byte parser step
	always_comb begin
		phase_d   = phase_q;
		status_d  = status_q;
		crc_d     = crc_q;
		crc_low_d = crc_low_q;
		count_d   = count_q;
		id_d      = id_q;
		hdr_d     = hdr_q;
		ctx_d     = ctx_q;
		len_d     = len_q;
		adr_d     = adr_q;
		res       = '0;
		if (byte_ch.payload.mode == MODE_RESTART) begin
			phase_d  = PH_ID;
			status_d = ST_IDLE;
		end else if (status_q != ST_COMPLETE && status_q != ST_CRCERR) begin
			case (phase_q)
				PH_ID: begin
					if (b == synth_id_q || b == ctrl_id_q || b == intr_id_q) begin
						id_d     = b;
						crc_d    = crc_upd;
						count_d  = '0;
						status_d = ST_PARSING;
						phase_d  = PH_HDR;
					end else begin
						status_d = ST_UNEXP;
					end
				end
				PH_HDR: begin
					hdr_d   = b;
					crc_d   = crc_upd;
					phase_d = PH_CTX;
				end
				PH_CTX: begin
					ctx_d   = b;
					crc_d   = crc_upd;
					phase_d = PH_LEN0;
				end
				PH_LEN0: begin
					len_d   = {len_q[15:8], b};
					crc_d   = crc_upd;
					phase_d = PH_LEN1;
				end
				PH_LEN1: begin
					len_d   = {b, len_q[7:0]};
					crc_d   = crc_upd;
					phase_d = PH_ADR0;
				end
				PH_ADR0: begin
					adr_d   = {adr_q[15:8], b};
					crc_d   = crc_upd;
					phase_d = PH_ADR1;
				end
				PH_ADR1: begin
					adr_d   = {b, adr_q[7:0]};
					crc_d   = crc_upd;
					phase_d = (len_q == 16'd0) ? PH_CRC0 : PH_DATA;
				end
				PH_DATA: begin
					res.data_byte  = b;
					res.data_valid = 1'b1;
					res.data_index = count_q;
					count_d        = count_inc;
					crc_d          = crc_upd;
					if (count_inc >= len_q) begin
						phase_d = PH_CRC0;
					end
				end
				PH_CRC0: begin
					crc_low_d = b;
					phase_d   = PH_CRC1;
				end
				PH_CRC1: begin
					status_d      = (crc_q == {b, crc_low_q}) ? ST_COMPLETE : ST_CRCERR;
					res.frame_end = 1'b1;
					phase_d       = PH_DONE;
				end
				default: ;
			endcase
		end
		res.status         = status_d;
		res.report_id      = id_d;
		res.header_byte    = hdr_d;
		res.context_byte   = ctx_d;
		res.frame_length   = len_d;
		res.target_address = adr_d;
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_ID;
			status_q  <= ST_IDLE;
			crc_q     <= '0;
			crc_low_q <= '0;
			count_q   <= '0;
			id_q      <= '0;
			hdr_q     <= '0;
			ctx_q     <= '0;
			len_q     <= '0;
			adr_q     <= '0;
		end else if (accept) begin
			phase_q   <= phase_d;
			status_q  <= status_d;
			crc_q     <= crc_d;
			crc_low_q <= crc_low_d;
			count_q   <= count_d;
			id_q      <= id_d;
			hdr_q     <= hdr_d;
			ctx_q     <= ctx_d;
			len_q     <= len_d;
			adr_q     <= adr_d;
		end
	end

	// result register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (report_ch.ready || !out_vld_q) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= accept;
			end
		end else if (accept) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (report_ch.ready || !out_vld_q) begin
			if (skid_vld_q) begin
				out_s1 <= skid_s1;
			end else if (accept) begin
				out_s1 <= res;
			end
		end else if (accept) begin
			skid_s1 <= res;
		end
	end

	assign byte_ch.ready     = !skid_vld_q;
	assign report_ch.valid   = out_vld_q;
	assign report_ch.payload = out_s1;

endmodule

// File: hdl/rfp_checker.sv
module rfp_checker import rfp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input rfp_report_t out_word
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	// after an accepted byte a result word is always valid in the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("no result word after accepted byte");

	// payload bytes only appear while a frame is being parsed
	a_data_parsing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.data_valid |-> out_word.status == ST_PARSING
			&& !out_word.frame_end)
		else $error("payload byte outside parsing");

	// the crc compare ends in complete or crc error
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.frame_end |-> out_word.status == ST_COMPLETE
			|| out_word.status == ST_CRCERR)
		else $error("frame end with wrong status");

endmodule

bind report_frame_parser_crc16_top rfp_checker u_rfp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (byte_ch.valid),
	.in_ready  (byte_ch.ready),
	.out_valid (report_ch.valid),
	.out_ready (report_ch.ready),
	.out_word  (report_ch.payload)
);

// File: bench/report_frame_parser_crc16_top_tb.sv
module report_frame_parser_crc16_top_tb;
	import rfp_pkg::*;

	typedef logic [7:0] octet_q_t [$];

	localparam int unsigned CycleLimit = 400000;
	localparam int unsigned HoldCycles = 60;
	localparam int unsigned DrainCycles = 8;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [1:0]              cfg_index;
	logic [CfgDataWidth-1:0] cfg_data;

	rfp_byte_if   byte_ch ();
	rfp_report_if report_ch ();

	report_frame_parser_crc16_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.byte_ch   (byte_ch),
		.report_ch (report_ch)
	);

	// configuration as the parser should hold it
	logic [15:0] poly_cfg;
	logic [7:0]  id_cfg [3];

	// parser state as predicted
	rfp_phase_t  frm_phase;
	rfp_status_t frm_status;
	logic [15:0] frm_crc;
	logic [7:0]  crc_lo_held;
	logic [15:0] data_count;
	logic [7:0]  id_seen;
	logic [7:0]  hdr_seen;
	logic [7:0]  ctx_seen;
	logic [15:0] len_seen;
	logic [15:0] addr_seen;

	rfp_report_t expected_reports [$];

	int unsigned tx_idle_pct = 0;
	int unsigned rx_stall_pct = 0;
	logic        hold_on = 1'b0;
	event        hold_go;

	int unsigned cycle_count = 0;
	int unsigned mismatches = 0;
	int unsigned words_sent = 0;
	int unsigned reports_seen = 0;
	int unsigned payload_bytes = 0;
	int unsigned frames_good = 0;
	int unsigned frames_bad = 0;
	int unsigned wrong_ids = 0;

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("timeout after %0d cycles, %0d reports outstanding", cycle_count,
				expected_reports.size());
			$display("report_frame_parser_crc16_top_tb: errors");
			$finish;
		end
	end

	// msb-first crc-16 over one byte, initial value handled by the caller
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b,
			input logic [15:0] poly);
		logic [16:0] acc;
		acc = {1'b0, crc ^ {b, 8'h00}};
		for (int k = 0; k < 8; k++) begin
			acc = {acc[15:0], 1'b0};
			if (acc[16]) begin
				acc[15:0] = acc[15:0] ^ poly;
			end
			acc[16] = 1'b0;
		end
		return acc[15:0];
	endfunction

	// advance the predicted parser by one word and queue the report it yields
	task automatic parse_byte(input rfp_byte_t w);
		rfp_report_t r;
		logic [7:0]  b;
		r = '0;
		b = w.rx_byte;
		if (w.mode == MODE_RESTART) begin
			frm_phase = PH_ID;
			frm_status = ST_IDLE;
		end else if (frm_status != ST_COMPLETE && frm_status != ST_CRCERR) begin
			case (frm_phase)
				PH_ID: begin
					if (b == id_cfg[0] || b == id_cfg[1] || b == id_cfg[2]) begin
						id_seen = b;
						frm_crc = crc_step(16'h0000, b, poly_cfg);
						data_count = 16'h0000;
						frm_status = ST_PARSING;
						frm_phase = PH_HDR;
					end else begin
						frm_status = ST_UNEXP;
						wrong_ids++;
					end
				end
				PH_HDR: begin
					hdr_seen = b;
					frm_crc = crc_step(frm_crc, b, poly_cfg);
					frm_phase = PH_CTX;
				end
				PH_CTX: begin
					ctx_seen = b;
					frm_crc = crc_step(frm_crc, b, poly_cfg);
					frm_phase = PH_LEN0;
				end
				PH_LEN0: begin
					len_seen[7:0] = b;
					frm_crc = crc_step(frm_crc, b, poly_cfg);
					frm_phase = PH_LEN1;
				end
				PH_LEN1: begin
					len_seen[15:8] = b;
					frm_crc = crc_step(frm_crc, b, poly_cfg);
					frm_phase = PH_ADR0;
				end
				PH_ADR0: begin
					addr_seen[7:0] = b;
					frm_crc = crc_step(frm_crc, b, poly_cfg);
					frm_phase = PH_ADR1;
				end
				PH_ADR1: begin
					addr_seen[15:8] = b;
					frm_crc = crc_step(frm_crc, b, poly_cfg);
					if (len_seen == 16'h0000) begin
						frm_phase = PH_CRC0;
					end else begin
						frm_phase = PH_DATA;
					end
				end
				PH_DATA: begin
					r.data_byte = b;
					r.data_valid = 1'b1;
					r.data_index = data_count;
					data_count = data_count + 16'd1;
					if (data_count >= len_seen) begin
						frm_phase = PH_CRC0;
					end
					frm_crc = crc_step(frm_crc, b, poly_cfg);
					payload_bytes++;
				end
				PH_CRC0: begin
					crc_lo_held = b;
					frm_phase = PH_CRC1;
				end
				PH_CRC1: begin
					if (frm_crc == {b, crc_lo_held}) begin
						frm_status = ST_COMPLETE;
						frames_good++;
					end else begin
						frm_status = ST_CRCERR;
						frames_bad++;
					end
					r.frame_end = 1'b1;
					frm_phase = PH_DONE;
				end
				default: begin
				end
			endcase
		end
		r.status = frm_status;
		r.report_id = id_seen;
		r.header_byte = hdr_seen;
		r.context_byte = ctx_seen;
		r.frame_length = len_seen;
		r.target_address = addr_seen;
		expected_reports.insert(expected_reports.size(), r);
	endtask

	function automatic string describe(input rfp_report_t r);
		return $sformatf("st=%0d id=%h hdr=%h ctx=%h len=%h adr=%h d=%h dv=%b di=%h end=%b",
			r.status, r.report_id, r.header_byte, r.context_byte, r.frame_length,
			r.target_address, r.data_byte, r.data_valid, r.data_index, r.frame_end);
	endfunction

	// result checker
	always @(posedge clk) begin
		if (report_ch.valid && report_ch.ready) begin
			reports_seen++;
			if (expected_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected report: %s", describe(report_ch.payload));
				end
			end else begin
				if (report_ch.payload !== expected_reports[0]) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("report mismatch\n  exp %s\n  got %s",
							describe(expected_reports[0]), describe(report_ch.payload));
					end
				end
				void'(expected_reports.pop_front());
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		report_ch.ready <= !hold_on && ($urandom_range(99) >= rx_stall_pct);
	end

	// long receiver hold-off, counted here
	always begin
		@(hold_go);
		hold_on <= 1'b1;
		repeat (HoldCycles) @(posedge clk);
		hold_on <= 1'b0;
	end

	// send one word, with random idle cycles ahead of it
	task automatic send_word(input rfp_mode_t m, input logic [7:0] b);
		rfp_byte_t w;
		w.mode = m;
		w.rx_byte = b;
		if ($urandom_range(99) < tx_idle_pct) begin
			byte_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.payload <= w;
		do @(posedge clk); while (!byte_ch.ready);
		words_sent++;
		parse_byte(w);
	endtask

	task automatic send_bytes(input octet_q_t q, input int n);
		for (int i = 0; i < n && i < q.size(); i++) begin
			send_word(MODE_BYTE, q[i]);
		end
	endtask

	// wire bytes of a frame with the crc for the current polynomial, xored with crc_flip
	function automatic octet_q_t build_frame(input logic [7:0] id, input logic [7:0] hdr,
			input logic [7:0] ctx, input logic [15:0] len, input logic [15:0] addr,
			input octet_q_t body, input logic [15:0] crc_flip);
		octet_q_t    q;
		logic [15:0] crc;
		q = {id, hdr, ctx, len[7:0], len[15:8], addr[7:0], addr[15:8]};
		foreach (body[i]) q = {q, body[i]};
		crc = 16'h0000;
		foreach (q[i]) crc = crc_step(crc, q[i], poly_cfg);
		crc = crc ^ crc_flip;
		q = {q, crc[7:0], crc[15:8]};
		return q;
	endfunction

	// wait until the parser has nothing in flight
	task automatic settle();
		byte_ch.valid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(input rfp_reg_t idx, input logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		case (idx)
			REG_CRC_POLY: poly_cfg = v;
			REG_SYNTH_ID: id_cfg[0] = v[7:0];
			REG_CTRL_ID:  id_cfg[1] = v[7:0];
			REG_INTR_ID:  id_cfg[2] = v[7:0];
			default: begin
			end
		endcase
	endtask

	task automatic load_config(input logic [15:0] poly, input logic [7:0] id0,
			input logic [7:0] id1, input logic [7:0] id2);
		put_reg(REG_CRC_POLY, poly);
		put_reg(REG_SYNTH_ID, {8'h00, id0});
		put_reg(REG_CTRL_ID, {8'h00, id1});
		put_reg(REG_INTR_ID, {8'h00, id2});
		cfg_we <= 1'b0;
	endtask

	// reset config: wrong id, empty frame, ignored byte after the check, restart
	task automatic test_reset_config();
		octet_q_t body;
		octet_q_t q;
		body = {};
		send_word(MODE_BYTE, 8'h33);
		q = build_frame(8'h00, 8'hFF, 8'h00, 16'h0000, 16'hFFFF, body, 16'h0000);
		send_bytes(q, q.size());
		send_word(MODE_BYTE, 8'hAB);
		send_word(MODE_RESTART, 8'hFF);
		settle();
	endtask

	// maximum length field, cut off by a restart inside the payload
	task automatic test_long_length();
		octet_q_t body;
		octet_q_t q;
		load_config(16'h8005, 8'h5A, 8'hFF, 8'h00);
		body = {8'hFF, 8'h00};
		q = build_frame(8'hFF, 8'h00, 8'hFF, 16'hFFFF, 16'h0000, body, 16'h0000);
		send_bytes(q, 9);
		send_word(MODE_RESTART, 8'h00);
		settle();
	endtask

	// receiver holds off while a long frame keeps coming
	task automatic test_backpressure();
		octet_q_t body;
		octet_q_t q;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		body = {};
		for (int i = 0; i < 30; i++) body = {body, 8'($urandom_range(255))};
		-> hold_go;
		q = build_frame(id_cfg[1], 8'h12, 8'h34, 16'd30, 16'hBEEF, body, 16'h0000);
		send_bytes(q, q.size());
		send_word(MODE_RESTART, 8'h00);
		settle();
	endtask

	// random traffic: mostly well-formed frames, some cut short, some noise
	task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
			input int unsigned n_words);
		int unsigned stop_at;
		int unsigned pick;
		int unsigned len;
		octet_q_t    body;
		octet_q_t    q;
		logic [15:0] flip;
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		stop_at = words_sent + n_words;
		while (words_sent < stop_at) begin
			pick = $urandom_range(99);
			len = ($urandom_range(15) == 0) ? $urandom_range(40) : $urandom_range(8);
			body = {};
			for (int i = 0; i < len; i++) body = {body, 8'($urandom_range(255))};
			flip = ($urandom_range(5) == 0) ? 16'(1 << $urandom_range(15)) : 16'h0000;
			q = build_frame(id_cfg[$urandom_range(2)], 8'($urandom_range(255)),
				8'($urandom_range(255)), 16'(len), 16'($urandom_range(65535)), body, flip);
			if (pick < 70) begin
				send_bytes(q, q.size());
				repeat ($urandom_range(2)) send_word(MODE_BYTE, 8'($urandom_range(255)));
				send_word(MODE_RESTART, 8'($urandom_range(255)));
			end else if (pick < 85) begin
				send_bytes(q, $urandom_range(q.size() - 1));
				send_word(MODE_RESTART, 8'($urandom_range(255)));
			end else begin
				repeat ($urandom_range(1, 3)) begin
					if ($urandom_range(3) == 0) begin
						send_word(MODE_RESTART, 8'($urandom_range(255)));
					end else begin
						send_word(MODE_BYTE, 8'($urandom_range(255)));
					end
				end
				if ($urandom_range(1) == 0) begin
					send_word(MODE_RESTART, 8'($urandom_range(255)));
				end
			end
		end
		settle();
	endtask

	initial begin
		// everything known from time zero
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_CRC_POLY;
		cfg_data = '0;
		byte_ch.valid = 1'b0;
		byte_ch.payload = '0;
		report_ch.ready = 1'b0;

		poly_cfg = CrcPolyReset;
		id_cfg[0] = 8'h00;
		id_cfg[1] = 8'h00;
		id_cfg[2] = 8'h00;
		frm_phase = PH_ID;
		frm_status = ST_IDLE;
		frm_crc = '0;
		crc_lo_held = '0;
		data_count = '0;
		id_seen = '0;
		hdr_seen = '0;
		ctx_seen = '0;
		len_seen = '0;
		addr_seen = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_config();
		test_long_length();
		test_backpressure();

		load_config(16'h1021, 8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)));
		test_random_traffic(0, 0, 475);
		load_config(16'hFFFF, 8'hFF, 8'hFF, 8'h00);
		test_random_traffic(64, 0, 475);
		load_config(16'h0000, 8'($urandom_range(255)), 8'h80, 8'h01);
		test_random_traffic(0, 64, 475);
		load_config(16'($urandom_range(65535)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)));
		test_random_traffic(36, 36, 475);

		// drain and let any stray report show up
		rx_stall_pct = 0;
		byte_ch.valid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (expected_reports.size() != 0) begin
			mismatches++;
		end

		$display("sent %0d words, checked %0d reports, %0d payload bytes", words_sent,
			reports_seen, payload_bytes);
		$display("frames passing crc %0d, failing crc %0d, rejected ids %0d, mismatches %0d",
			frames_good, frames_bad, wrong_ids, mismatches);
		if (mismatches == 0) begin
			$display("report_frame_parser_crc16_top_tb: clean");
		end else begin
			$display("report_frame_parser_crc16_top_tb: errors");
		end
		$finish;
	end

endmodule
